// ----- hdl/tceu_pkg.sv -----
// ----------------------------------------------------------------------------
// Tracker channel effect unit package
// Shared types and constants: request and response words, the per-channel
// state record and the effect letter and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tceu_pkg;

   // Input word of one tick.
   typedef struct packed {
      logic        kind;
      logic [7:0]  effect_code;
      logic [7:0]  effect_param;
      logic [7:0]  vol_column;
      logic        note_valid;
      logic [15:0] note_period;
      logic [6:0]  note_volume;
      logic        voice_active;
   } req_type;

   // Result word of one tick.
   typedef struct packed {
      logic [6:0]  cur_volume;
      logic [6:0]  cur_channel_volume;
      logic [6:0]  cur_panning;
      logic [15:0] cur_period;
      logic        period_changed;
   } rsp_type;

   // Channel state apart from the period and the portamento target.
   typedef struct packed {
      logic [6:0] note_vol;
      logic [6:0] chan_vol;
      logic [6:0] pan_pos;
      logic [7:0] vol_slide_mem;
      logic [7:0] chan_slide_mem;
      logic [7:0] pitch_slide_mem;
      logic [7:0] porta_mem;
      logic       fine_flag;
   } chan_state_type;

   localparam logic [6:0] VOL_MAX    = 7'd64;
   localparam logic [6:0] PAN_CENTER = 7'd32;

   localparam chan_state_type CHAN_STATE_RESET = '{
      note_vol:        7'd0,
      chan_vol:        VOL_MAX,
      pan_pos:         PAN_CENTER,
      vol_slide_mem:   8'd0,
      chan_slide_mem:  8'd0,
      pitch_slide_mem: 8'd0,
      porta_mem:       8'd0,
      fine_flag:       1'b0
   };

   // Effect letters (ASCII).
   localparam logic [7:0] FX_D = 8'h44;
   localparam logic [7:0] FX_E = 8'h45;
   localparam logic [7:0] FX_F = 8'h46;
   localparam logic [7:0] FX_G = 8'h47;
   localparam logic [7:0] FX_K = 8'h4B;
   localparam logic [7:0] FX_L = 8'h4C;
   localparam logic [7:0] FX_M = 8'h4D;
   localparam logic [7:0] FX_N = 8'h4E;
   localparam logic [7:0] FX_X = 8'h58;

   // Register port: byte address bits and register index.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-3:0] CSR_IDX_COMPAT_GXX = '0;

endpackage

`default_nettype wire

// ----- hdl/tceu_fx.sv -----
// ----------------------------------------------------------------------------
// Tracker channel effect unit - tick datapath
// Combinational next-state logic for one tick: note trigger (first tick only),
// volume column, then the effect letter, with slide memories and period saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tceu_fx
   import tceu_pkg::*;
#(
   parameter int PERIOD_BITS = 16
) (
   input  req_type                  req,
   input  logic                     compat_gxx,
   input  chan_state_type           st_cur,
   input  logic [PERIOD_BITS-1:0]   period_cur,
   input  logic [PERIOD_BITS-1:0]   target_cur,
   output chan_state_type           st_nxt,
   output logic [PERIOD_BITS-1:0]   period_nxt,
   output logic [PERIOD_BITS-1:0]   target_nxt,
   output logic                     period_wr
);

   // Two extra bits: one for headroom above the maximum, one for sign.
   localparam int PW = PERIOD_BITS + 2;
   localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;

   localparam logic [3:0] NIB_E = 4'hE;
   localparam logic [3:0] NIB_F = 4'hF;

   // Volume column code ranges.
   localparam logic [7:0] VC_VOL_HI     = 8'd64;
   localparam logic [7:0] VC_FUP_LO     = 8'd65;
   localparam logic [7:0] VC_FUP_HI     = 8'd74;
   localparam logic [7:0] VC_FDN_LO     = 8'd75;
   localparam logic [7:0] VC_FDN_HI     = 8'd84;
   localparam logic [7:0] VC_VUP_LO     = 8'd85;
   localparam logic [7:0] VC_VUP_HI     = 8'd94;
   localparam logic [7:0] VC_VDN_LO     = 8'd95;
   localparam logic [7:0] VC_VDN_HI     = 8'd104;
   localparam logic [7:0] VC_PDN_LO     = 8'd105;
   localparam logic [7:0] VC_PDN_HI     = 8'd114;
   localparam logic [7:0] VC_PUP_LO     = 8'd115;
   localparam logic [7:0] VC_PUP_HI     = 8'd124;
   localparam logic [7:0] VC_PAN_LO     = 8'd128;
   localparam logic [7:0] VC_PAN_HI     = 8'd192;

   function automatic logic [PERIOD_BITS-1:0] sat_period(input logic [PW-1:0] v);
      logic [PERIOD_BITS-1:0] r;
      if (v[PW-1]) begin
         r = '0;
      end else if (v[PW-2]) begin
         r = PERIOD_MAX;
      end else begin
         r = v[PERIOD_BITS-1:0];
      end
      return r;
   endfunction

   function automatic logic [PERIOD_BITS-1:0] step_period(
      input logic [PERIOD_BITS-1:0] p,
      input logic [9:0]             amt,
      input logic                   down
   );
      logic [PW-1:0] s;
      if (down) begin
         s = PW'(p) + PW'(amt);
      end else begin
         s = PW'(p) - PW'(amt);
      end
      return sat_period(s);
   endfunction

   // Volume plus a signed delta of -15..15, clamped to 0..64.
   function automatic logic [6:0] vol_add(input logic [6:0] vol, input logic [4:0] d);
      logic [7:0] s;
      logic [6:0] r;
      s = {1'b0, vol} + {{3{d[4]}}, d};
      if (s[7]) begin
         r = '0;
      end else if (s > {1'b0, VOL_MAX}) begin
         r = VOL_MAX;
      end else begin
         r = s[6:0];
      end
      return r;
   endfunction

   // First-tick slide: only the fine forms move the volume.
   function automatic logic [4:0] fine_delta(input logic [7:0] mem);
      logic [3:0] x;
      logic [3:0] y;
      logic [4:0] r;
      x = mem[7:4];
      y = mem[3:0];
      if (y == 4'd0) begin
         r = (x == NIB_F) ? 5'd15 : 5'd0;
      end else if (x == 4'd0) begin
         r = (y == NIB_F) ? (5'd0 - 5'd15) : 5'd0;
      end else if (y == NIB_F) begin
         r = {1'b0, x};
      end else if (x == NIB_F) begin
         r = 5'd0 - {1'b0, y};
      end else begin
         r = 5'd0;
      end
      return r;
   endfunction

   // Later-tick slide: a plain up or down nibble.
   function automatic logic [4:0] coarse_delta(input logic [7:0] mem);
      logic [4:0] r;
      if (mem[3:0] == 4'd0) begin
         r = {1'b0, mem[7:4]};
      end else if (mem[7:4] == 4'd0) begin
         r = 5'd0 - {1'b0, mem[3:0]};
      end else begin
         r = 5'd0;
      end
      return r;
   endfunction

   always_comb begin
      chan_state_type         st;
      logic [PERIOD_BITS-1:0] per;
      logic [PERIOD_BITS-1:0] tgt;
      logic                   wr;
      logic [PERIOD_BITS-1:0] np;
      logic [7:0]             vc;
      logic [7:0]             fx;
      logic [7:0]             prm;
      logic [7:0]             vd;
      logic                   vs_en;
      logic [7:0]             vs_prm;
      logic                   ps_en;
      logic                   ps_down;
      logic [7:0]             ps_prm;
      logic [5:0]             fine_amt;
      logic [PW-1:0]          delta_p;
      logic [PW-1:0]          mag;
      logic [PW-1:0]          step;
      logic [13:0]            pan_x;
      logic [14:0]            pan_s;

      st       = st_cur;
      per      = period_cur;
      tgt      = target_cur;
      wr       = 1'b0;
      vc       = req.vol_column;
      fx       = req.effect_code;
      prm      = req.effect_param;
      vd       = '0;
      vs_en    = 1'b0;
      vs_prm   = '0;
      ps_en    = 1'b0;
      ps_down  = 1'b0;
      ps_prm   = '0;
      fine_amt = '0;
      delta_p  = PW'(period_cur) - PW'(target_cur);
      mag      = '0;
      step     = '0;
      pan_x    = {prm, 6'd0};
      // prm * 64 / 255 through a reciprocal form that is exact for these 14-bit values.
      pan_s    = 15'(pan_x) + 15'(pan_x[13:8]) + 15'd1;

      if (32'(req.note_period) > 32'(PERIOD_MAX)) begin
         np = PERIOD_MAX;
      end else begin
         np = PERIOD_BITS'(req.note_period);
      end

      if (!req.kind) begin
         // Note trigger. A portamento onto a playing voice only moves the target.
         if (req.note_valid) begin
            tgt = np;
            if (!(req.voice_active && (fx == FX_G || fx == FX_L))) begin
               per         = np;
               wr          = 1'b1;
               st.note_vol = (req.note_volume > VOL_MAX) ? VOL_MAX : req.note_volume;
            end
         end

         // Volume column.
         if (vc <= VC_VOL_HI) begin
            st.note_vol = vc[6:0];
         end else if (vc >= VC_PAN_LO && vc <= VC_PAN_HI) begin
            vd         = vc - VC_PAN_LO;
            st.pan_pos = vd[6:0];
         end else if (vc <= VC_FUP_HI) begin
            vd     = vc - VC_FUP_LO;
            vs_en  = 1'b1;
            vs_prm = {vd[3:0], NIB_F};
         end else if (vc <= VC_FDN_HI) begin
            vd     = vc - VC_FDN_LO;
            vs_en  = 1'b1;
            vs_prm = {NIB_F, vd[3:0]};
         end else if (vc <= VC_VUP_HI) begin
            vd     = vc - VC_VUP_LO;
            vs_en  = 1'b1;
            vs_prm = {vd[3:0], 4'd0};
         end else if (vc <= VC_VDN_HI) begin
            vd     = vc - VC_VDN_LO;
            vs_en  = 1'b1;
            vs_prm = {4'd0, vd[3:0]};
         end else if (vc <= VC_PDN_HI) begin
            vd      = vc - VC_PDN_LO;
            ps_en   = 1'b1;
            ps_down = 1'b1;
            ps_prm  = {vd[5:0], 2'b00};
         end else if (vc <= VC_PUP_HI) begin
            vd      = vc - VC_PUP_LO;
            ps_en   = 1'b1;
            ps_prm  = {vd[5:0], 2'b00};
         end

         if (vs_en) begin
            if (vs_prm != 8'd0) begin
               st.vol_slide_mem = vs_prm;
            end
            st.note_vol = vol_add(st.note_vol, fine_delta(st.vol_slide_mem));
         end
         if (ps_en) begin
            if (ps_prm != 8'd0) begin
               st.pitch_slide_mem = ps_prm;
               if (!compat_gxx) begin
                  st.porta_mem = ps_prm;
               end
            end
            if (st.pitch_slide_mem[7:4] == NIB_E || st.pitch_slide_mem[7:4] == NIB_F) begin
               fine_amt = (st.pitch_slide_mem[7:4] == NIB_F) ?
                          {st.pitch_slide_mem[3:0], 2'b00} : {2'b00, st.pitch_slide_mem[3:0]};
               per          = step_period(per, 10'(fine_amt), ps_down);
               wr           = 1'b1;
               st.fine_flag = 1'b1;
            end else begin
               st.fine_flag = 1'b0;
            end
         end

         // Effect letter.
         vs_en   = 1'b0;
         ps_en   = 1'b0;
         ps_down = 1'b0;
         unique case (fx) inside
            FX_D, FX_K, FX_L: begin
               vs_en  = 1'b1;
               vs_prm = prm;
            end
            FX_E: begin
               ps_en   = 1'b1;
               ps_down = 1'b1;
               ps_prm  = prm;
            end
            FX_F: begin
               ps_en  = 1'b1;
               ps_prm = prm;
            end
            FX_G: begin
               if (prm != 8'd0) begin
                  st.porta_mem = prm;
                  if (!compat_gxx) begin
                     st.pitch_slide_mem = prm;
                     st.fine_flag       = (prm[7:4] >= NIB_E);
                  end
               end
            end
            FX_M: begin
               if (prm <= {1'b0, VOL_MAX}) begin
                  st.chan_vol = prm[6:0];
               end
            end
            FX_N: begin
               if (prm != 8'd0) begin
                  st.chan_slide_mem = prm;
               end
               st.chan_vol = vol_add(st.chan_vol, fine_delta(st.chan_slide_mem));
            end
            FX_X: begin
               st.pan_pos = pan_s[14:8];
            end
            default: begin
            end
         endcase

         if (vs_en) begin
            if (vs_prm != 8'd0) begin
               st.vol_slide_mem = vs_prm;
            end
            st.note_vol = vol_add(st.note_vol, fine_delta(st.vol_slide_mem));
         end
         if (ps_en) begin
            if (ps_prm != 8'd0) begin
               st.pitch_slide_mem = ps_prm;
               if (!compat_gxx) begin
                  st.porta_mem = ps_prm;
               end
            end
            if (st.pitch_slide_mem[7:4] == NIB_E || st.pitch_slide_mem[7:4] == NIB_F) begin
               fine_amt = (st.pitch_slide_mem[7:4] == NIB_F) ?
                          {st.pitch_slide_mem[3:0], 2'b00} : {2'b00, st.pitch_slide_mem[3:0]};
               per          = step_period(per, 10'(fine_amt), ps_down);
               wr           = 1'b1;
               st.fine_flag = 1'b1;
            end else begin
               st.fine_flag = 1'b0;
            end
         end
      end else begin
         // Later tick: volume column slides first.
         if (vc >= VC_FUP_LO && vc <= VC_VDN_HI) begin
            st.note_vol = vol_add(st.note_vol, coarse_delta(st.vol_slide_mem));
         end else if (vc >= VC_PDN_LO && vc <= VC_PDN_HI) begin
            if (!st.fine_flag) begin
               per = step_period(per, {st.pitch_slide_mem, 2'b00}, 1'b1);
               wr  = 1'b1;
            end
         end else if (vc >= VC_PUP_LO && vc <= VC_PUP_HI) begin
            if (!st.fine_flag) begin
               per = step_period(per, {st.pitch_slide_mem, 2'b00}, 1'b0);
               wr  = 1'b1;
            end
         end

         unique case (fx) inside
            FX_G, FX_L: begin
               // Tone portamento toward the target, landing on it exactly.
               delta_p = PW'(per) - PW'(tgt);
               step    = PW'({st.porta_mem, 2'b00});
               mag     = delta_p[PW-1] ? ('0 - delta_p) : delta_p;
               if (delta_p != '0) begin
                  if (step > mag) begin
                     per = tgt;
                  end else if (!delta_p[PW-1]) begin
                     per = sat_period(PW'(per) - step);
                  end else begin
                     per = sat_period(PW'(per) + step);
                  end
                  wr = 1'b1;
               end
               if (fx == FX_L) begin
                  st.note_vol = vol_add(st.note_vol, coarse_delta(st.vol_slide_mem));
               end
            end
            FX_D, FX_K: begin
               st.note_vol = vol_add(st.note_vol, coarse_delta(st.vol_slide_mem));
            end
            FX_E: begin
               if (!st.fine_flag) begin
                  per = step_period(per, {st.pitch_slide_mem, 2'b00}, 1'b1);
                  wr  = 1'b1;
               end
            end
            FX_F: begin
               if (!st.fine_flag) begin
                  per = step_period(per, {st.pitch_slide_mem, 2'b00}, 1'b0);
                  wr  = 1'b1;
               end
            end
            FX_N: begin
               st.chan_vol = vol_add(st.chan_vol, coarse_delta(st.chan_slide_mem));
            end
            default: begin
            end
         endcase
      end

      st_nxt     = st;
      period_nxt = per;
      target_nxt = tgt;
      period_wr  = wr;
   end

endmodule

`default_nettype wire

// ----- hdl/tracker_channel_effect_unit.sv -----
// ----------------------------------------------------------------------------
// Tracker channel effect unit
// Steps one tracker channel's volume, panning and pitch state once per tick.
// ----------------------------------------------------------------------------
// Path: a taken request word is held in the input register, then written to the result register.
// Throughput: one word per cycle; the tick logic between the input register
// and the result register is a single pass, and a stalled result register
// blocks new words only once the input register is also full.
// Reset: synchronous, active high; empties both registers, restores the
// channel state and the compat_gxx register to their defaults.
`default_nettype none

module tracker_channel_effect_unit
   import tceu_pkg::*;
#(
   parameter int PERIOD_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,

   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   // Handshake state of the two word registers.
   logic                   in_valid_ff;
   req_type                in_word_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_word_ff;
   rsp_type                rsp_word_in;

   // Channel state. It is updated only when a word moves from the input
   // register into the result register, so the next word always sees the
   // state that the previous tick left.
   chan_state_type         chan_ff;
   chan_state_type         chan_in;
   logic [PERIOD_BITS-1:0] period_ff;
   logic [PERIOD_BITS-1:0] period_in;
   logic [PERIOD_BITS-1:0] target_ff;
   logic [PERIOD_BITS-1:0] target_in;
   logic                   period_wr;

   logic                   compat_gxx_ff;

   logic                   out_free;
   logic                   advance;
   logic                   csr_wr;
   logic                   csr_hit;

   // The result register can take a word when it is empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   tceu_fx #(
      .PERIOD_BITS (PERIOD_BITS)
   ) u_fx (
      .req        (in_word_ff),
      .compat_gxx (compat_gxx_ff),
      .st_cur     (chan_ff),
      .period_cur (period_ff),
      .target_cur (target_ff),
      .st_nxt     (chan_in),
      .period_nxt (period_in),
      .target_nxt (target_in),
      .period_wr  (period_wr)
   );

   // The result reports the state after the tick; the period port keeps the
   // low sixteen bits of the period register.
   always_comb begin
      rsp_word_in.cur_volume         = chan_in.note_vol;
      rsp_word_in.cur_channel_volume = chan_in.chan_vol;
      rsp_word_in.cur_panning        = chan_in.pan_pos;
      rsp_word_in.cur_period         = 16'(period_in);
      rsp_word_in.period_changed     = period_wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff   <= CHAN_STATE_RESET;
         period_ff <= '0;
         target_ff <= '0;
      end else if (advance) begin
         chan_ff   <= chan_in;
         period_ff <= period_in;
         target_ff <= target_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   // Register port. Writes complete in the access phase; there are no wait
   // states. Only the compat_gxx register exists, and other addresses read
   // as zero and ignore writes.
   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_BITS-1:2] == CSR_IDX_COMPAT_GXX);
   assign csr_wr  = psel && penable && pwrite && pready && csr_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         compat_gxx_ff <= 1'b0;
      end else if (csr_wr) begin
         compat_gxx_ff <= pwdata[0];
      end
   end

   assign prdata = csr_hit ? CSR_DATA_BITS'(compat_gxx_ff) : '0;

endmodule

`default_nettype wire

// ----- hdl/tceu_check.sv -----
// ----------------------------------------------------------------------------
// Tracker channel effect unit - port checker
// Watches the top level's ports and is attached to it by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module tceu_check
   import tceu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_ready,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  rsp_type                  rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   input  logic [CSR_DATA_BITS-1:0] prdata,
   input  logic                     pready
);

   // Volumes and panning are clamped to the 0..64 range.
   a_levels_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.cur_volume <= VOL_MAX &&
                     rsp_data.cur_channel_volume <= VOL_MAX &&
                     rsp_data.cur_panning <= VOL_MAX))
      else $error("level field above 64");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // With no result waiting the unit must be able to take a request.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with an empty result register");

   // Reset empties the unit and clears the register.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready && prdata == '0)
      else $error("unit not empty after reset");

   // A register write is read back on the following cycle.
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready &&
      paddr[CSR_ADDR_BITS-1:2] == CSR_IDX_COMPAT_GXX
      |=> (paddr[CSR_ADDR_BITS-1:2] != CSR_IDX_COMPAT_GXX ||
           prdata[0] == $past(pwdata[0])))
      else $error("compat_gxx readback mismatch");

endmodule

bind tracker_channel_effect_unit tceu_check u_tceu_check (.*);

`default_nettype wire
